FILE: sv/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// shared constants and types of the point projector
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ENTRY_COUNT   = 12;
  localparam int IDX_W         = 4;
  localparam int WORD_W        = 32;
  localparam int SIZE_W        = 14;
  localparam int OFS_W         = 16;
  localparam int QUOT_BITS     = 40;
  localparam int CFG_IDX_W     = 2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 2'd3;

  // control bits that travel beside the data
  typedef struct packed {
    logic valid;
    logic visible;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } side_t;

endpackage

FILE: sv/perspective_point_projector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_projector_top
// vertex projection through a loaded matrix onto a viewport
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall   | opcode, entry index/value, point
//  out_    | output    | out_valid/out_stall | screen x, screen y, visible
//  cfg_    | input     | cfg_valid/cfg_ready | register index, data
//
//  one word per cycle while in_stall is low; a project word passes six stages
//  ahead of the 40 stage divider, then the output register
//  load words update the matrix and give no result
//  rst_n is synchronous; it clears valid bits and the offsets and sets the
//  frame sizes to one; the matrix holds nothing defined until loaded
//  the whole pipe advances when the output register is empty or taken;
//  in_stall is high exactly when a held result is stalled
// ----------------------------------------------------------------------------
module perspective_point_projector_top #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [ppp_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [ppp_pkg::WORD_W-1:0] in_entry_value,
  input  logic signed [ppp_pkg::WORD_W-1:0] in_point_x,
  input  logic signed [ppp_pkg::WORD_W-1:0] in_point_y,
  input  logic signed [ppp_pkg::WORD_W-1:0] in_point_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ppp_pkg::WORD_W-1:0] out_screen_x,
  output logic signed [ppp_pkg::WORD_W-1:0] out_screen_y,
  output logic                              out_visible,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppp_pkg::OFS_W-1:0]         cfg_data
);
  import ppp_pkg::*;

  localparam int  SUM_W   = 66 - FRAC_BITS;   // clip value width
  localparam int  MAG_W   = SUM_W + 1;        // |x + w| width
  localparam int  DEN_W   = SUM_W - 1;        // positive w width
  localparam int  PRD_W   = MAG_W + SIZE_W;
  localparam int  NUM_W   = PRD_W + FRAC_BITS - 1;
  localparam int  RES_W   = QUOT_BITS + 3;
  localparam longint W_MIN = (longint'(1) << FRAC_BITS) / 1000;

  // global advance
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // viewport registers
  logic [SIZE_W-1:0]       fw_r, fh_r;
  logic signed [OFS_W-1:0] ofx_r, ofy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= SIZE_W'(1);
      fh_r  <= SIZE_W'(1);
      ofx_r <= '0;
      ofy_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: fh_r  <= cfg_data[SIZE_W-1:0];
        REG_OFFSET_X:     ofx_r <= cfg_data;
        REG_OFFSET_Y:     ofy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: capture the point
  logic                     in_take;
  logic                     v0_r, v1_r, v2_r;
  logic signed [WORD_W-1:0] px_r, py_r, pz_r;

  assign in_take = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid && (in_opcode == OP_PROJECT);
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
      pz_r <= in_point_z;
    end
  end

  // stages 1 and 2: clip coordinates
  logic signed [SUM_W-1:0] cx, cy, cw;

  ppp_clip #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_clip (
    .clk      (clk),
    .en       (adv),
    .load_en  (in_take && (in_opcode == OP_LOAD)),
    .load_idx (in_entry_index),
    .load_val (in_entry_value),
    .pt_x     (px_r),
    .pt_y     (py_r),
    .pt_z     (pz_r),
    .cx       (cx),
    .cy       (cy),
    .cw       (cw)
  );

  // stage 3: visibility test, numerators x + w and w - y as sign/magnitude
  logic signed [SUM_W-1:0] w_min_c;
  logic signed [MAG_W-1:0] nx, ny;
  side_t                   side3_r, side4_r, side5_r;
  logic [MAG_W-1:0]        ax3_r, ay3_r;
  logic [DEN_W-1:0]        den3_r, den4_r, den5_r;

  assign w_min_c = SUM_W'(W_MIN);
  assign nx = MAG_W'(cx) + MAG_W'(cw);
  assign ny = MAG_W'(cw) - MAG_W'(cy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r.valid <= 1'b0;
    end else if (adv) begin
      side3_r.valid <= v2_r;
    end
    if (adv) begin
      side3_r.visible <= cw > w_min_c;
      side3_r.neg_x   <= nx[MAG_W-1];
      side3_r.neg_y   <= ny[MAG_W-1];
      side3_r.ovf_x   <= 1'b0;
      side3_r.ovf_y   <= 1'b0;
      ax3_r           <= nx[MAG_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
      ay3_r           <= ny[MAG_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
      den3_r          <= cw[DEN_W-1:0];
    end
  end

  // stage 4: scale by viewport size
  logic [PRD_W-1:0] mx4_r, my4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r.valid <= 1'b0;
    end else if (adv) begin
      side4_r.valid <= side3_r.valid;
    end
    if (adv) begin
      side4_r.visible <= side3_r.visible;
      side4_r.neg_x   <= side3_r.neg_x;
      side4_r.neg_y   <= side3_r.neg_y;
      side4_r.ovf_x   <= 1'b0;
      side4_r.ovf_y   <= 1'b0;
      mx4_r           <= PRD_W'(ax3_r) * PRD_W'(fw_r);
      my4_r           <= PRD_W'(ay3_r) * PRD_W'(fh_r);
      den4_r          <= den3_r;
    end
  end

  // stage 5: split numerator, cap test against 2^40 * w
  logic [NUM_W-1:0]     numx, numy;
  logic [DEN_W-1:0]     hix, hiy;
  logic [DEN_W-1:0]     remx5_r, remy5_r;
  logic [QUOT_BITS-1:0] lox5_r, loy5_r;

  assign numx = {mx4_r, {(FRAC_BITS-1){1'b0}}};
  assign numy = {my4_r, {(FRAC_BITS-1){1'b0}}};
  assign hix  = DEN_W'(numx >> QUOT_BITS);
  assign hiy  = DEN_W'(numy >> QUOT_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r.valid <= 1'b0;
    end else if (adv) begin
      side5_r.valid <= side4_r.valid;
    end
    if (adv) begin
      side5_r.visible <= side4_r.visible;
      side5_r.neg_x   <= side4_r.neg_x;
      side5_r.neg_y   <= side4_r.neg_y;
      side5_r.ovf_x   <= hix >= den4_r;
      side5_r.ovf_y   <= hiy >= den4_r;
      remx5_r         <= hix;
      remy5_r         <= hiy;
      lox5_r          <= numx[QUOT_BITS-1:0];
      loy5_r          <= numy[QUOT_BITS-1:0];
      den5_r          <= den4_r;
    end
  end

  // divider lanes, side bits kept in step
  logic [QUOT_BITS-1:0] qx, qy;
  side_t                side_line_r [QUOT_BITS];

  ppp_div #(.DEN_W(DEN_W)) u_div_x (
    .clk  (clk),
    .en   (adv),
    .den  (den5_r),
    .rem0 (remx5_r),
    .lo0  (lox5_r),
    .quot (qx)
  );

  ppp_div #(.DEN_W(DEN_W)) u_div_y (
    .clk  (clk),
    .en   (adv),
    .den  (den5_r),
    .rem0 (remy5_r),
    .lo0  (loy5_r),
    .quot (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUOT_BITS; k++) begin
        side_line_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      side_line_r[0].valid <= side5_r.valid;
      for (int k = 1; k < QUOT_BITS; k++) begin
        side_line_r[k].valid <= side_line_r[k-1].valid;
      end
    end
    if (adv) begin
      side_line_r[0].visible <= side5_r.visible;
      side_line_r[0].neg_x   <= side5_r.neg_x;
      side_line_r[0].neg_y   <= side5_r.neg_y;
      side_line_r[0].ovf_x   <= side5_r.ovf_x;
      side_line_r[0].ovf_y   <= side5_r.ovf_y;
      for (int k = 1; k < QUOT_BITS; k++) begin
        side_line_r[k].visible <= side_line_r[k-1].visible;
        side_line_r[k].neg_x   <= side_line_r[k-1].neg_x;
        side_line_r[k].neg_y   <= side_line_r[k-1].neg_y;
        side_line_r[k].ovf_x   <= side_line_r[k-1].ovf_x;
        side_line_r[k].ovf_y   <= side_line_r[k-1].ovf_y;
      end
    end
  end

  // output stage: cap, sign, offset, saturate
  side_t                    sd;
  logic [QUOT_BITS:0]       capx, capy;
  logic signed [RES_W-1:0]  rx, ry;
  logic signed [WORD_W-1:0] sx_nxt, sy_nxt;
  logic signed [WORD_W-1:0] sx_r, sy_r;
  logic                     vis_r;

  localparam logic [QUOT_BITS:0] QCAP = {1'b1, {QUOT_BITS{1'b0}}};
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32'sh7fffffff);
  localparam logic signed [RES_W-1:0] SAT_LO = -(RES_W'(32'sh7fffffff)) - RES_W'(1);

  assign sd   = side_line_r[QUOT_BITS-1];
  assign capx = sd.ovf_x ? QCAP : {1'b0, qx};
  assign capy = sd.ovf_y ? QCAP : {1'b0, qy};

  always_comb begin
    rx = sd.neg_x ? -RES_W'(capx) : RES_W'(capx);
    ry = sd.neg_y ? -RES_W'(capy) : RES_W'(capy);
    rx = rx + (RES_W'(ofx_r) <<< FRAC_BITS);
    ry = ry + (RES_W'(ofy_r) <<< FRAC_BITS);
    if (rx > SAT_HI) begin
      sx_nxt = WORD_W'(SAT_HI);
    end else if (rx < SAT_LO) begin
      sx_nxt = WORD_W'(SAT_LO);
    end else begin
      sx_nxt = rx[WORD_W-1:0];
    end
    if (ry > SAT_HI) begin
      sy_nxt = WORD_W'(SAT_HI);
    end else if (ry < SAT_LO) begin
      sy_nxt = WORD_W'(SAT_LO);
    end else begin
      sy_nxt = ry[WORD_W-1:0];
    end
    if (!sd.visible) begin
      sx_nxt = '0;
      sy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      vis_r <= sd.visible;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = sx_r;
  assign out_screen_y = sy_r;
  assign out_visible  = vis_r;

`ifndef SYNTHESIS
  // hidden points carry zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !vis_r |-> (sx_r == '0) && (sy_r == '0))
    else $error("hidden point with nonzero coordinates");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  // a stalled pipe keeps its valid bits in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(side5_r.valid) && $stable(side_line_r[QUOT_BITS-1].valid))
    else $error("pipe moved while stalled");

  // only a project word enters the valid line
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_LOAD) |=> !v0_r)
    else $error("load word produced a result slot");
`endif

endmodule

FILE: sv/ppp_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_clip
// matrix store and two-stage clip x, y, w computation
// ----------------------------------------------------------------------------
module ppp_clip #(
  parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
  parameter int SUM_W     = 66 - FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic                             load_en,
  input  logic [ppp_pkg::IDX_W-1:0]        load_idx,
  input  logic signed [ppp_pkg::WORD_W-1:0] load_val,
  input  logic signed [ppp_pkg::WORD_W-1:0] pt_x,
  input  logic signed [ppp_pkg::WORD_W-1:0] pt_y,
  input  logic signed [ppp_pkg::WORD_W-1:0] pt_z,
  output logic signed [SUM_W-1:0]          cx,
  output logic signed [SUM_W-1:0]          cy,
  output logic signed [SUM_W-1:0]          cw
);
  import ppp_pkg::*;

  localparam int PROD_W = 2 * WORD_W;

  logic signed [WORD_W-1:0] mat_r [ENTRY_COUNT];
  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [WORD_W-1:0] trans_r [3];
  logic signed [SUM_W-1:0]  sum_nxt [3];
  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [WORD_W-1:0] pts [3];
  logic                     ld_r;
  logic [IDX_W-1:0]         ld_idx_r;
  logic signed [WORD_W-1:0] ld_val_r;

  assign pts[0] = pt_x;
  assign pts[1] = pt_y;
  assign pts[2] = pt_z;

  // a load passes through a register before it lands, in step with the point
  // register ahead of the products, so it only reaches points taken after it
  always_ff @(posedge clk) begin
    if (en) begin
      ld_r     <= load_en;
      ld_idx_r <= load_idx;
      ld_val_r <= load_val;
      if (ld_r && (ld_idx_r < IDX_W'(ENTRY_COUNT))) begin
        mat_r[ld_idx_r] <= ld_val_r;
      end
    end
  end

  // stage 1: nine products, translations captured
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r*3+k] <= mat_r[r*4+k] * pts[k];
        end
        trans_r[r] <= mat_r[r*4+3];
      end
    end
  end

  // stage 2: floor shift and row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = SUM_W'(trans_r[r]);
      for (int k = 0; k < 3; k++) begin
        sum_nxt[r] = sum_nxt[r] + SUM_W'(prod_r[r*3+k] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= sum_nxt[r];
      end
    end
  end

  assign cx = sum_r[0];
  assign cy = sum_r[1];
  assign cw = sum_r[2];

endmodule

FILE: sv/ppp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ppp_div #(
  parameter int DEN_W = 49
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [DEN_W-1:0]                den,
  input  logic [DEN_W-1:0]                rem0,
  input  logic [ppp_pkg::QUOT_BITS-1:0]   lo0,
  output logic [ppp_pkg::QUOT_BITS-1:0]   quot
);
  import ppp_pkg::*;

  logic [DEN_W-1:0]     den_r [QUOT_BITS];
  logic [DEN_W-1:0]     rem_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] lo_r  [QUOT_BITS];
  logic [QUOT_BITS-1:0] q_r   [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    logic [DEN_W-1:0]     den_in;
    logic [DEN_W-1:0]     rem_in;
    logic [QUOT_BITS-1:0] lo_in;
    logic [QUOT_BITS-1:0] q_in;
    logic [DEN_W:0]       trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign den_in = den;
      assign rem_in = rem0;
      assign lo_in  = lo0;
      assign q_in   = '0;
    end else begin : g_next
      assign den_in = den_r[k-1];
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = {rem_in, lo_in[QUOT_BITS-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        rem_r[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
        lo_r[k]  <= {lo_in[QUOT_BITS-2:0], 1'b0};
        q_r[k]   <= {q_in[QUOT_BITS-2:0], ge};
      end
    end
  end

  assign quot = q_r[QUOT_BITS-1];

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the point projector word by word against an in-bench predictor of
// matrix loads, clip-space sums, visibility, viewport scaling and saturation,
// under random idling on both channels and a long output hold-off
// ----------------------------------------------------------------------------
module testbench;
  import ppp_pkg::*;

  localparam int FB         = FRAC_BITS_DEF;
  localparam longint W_MIN  = (longint'(1) << FB) / 1000;
  localparam longint Q_CAP  = longint'(1) << QUOT_BITS;
  localparam int DRAIN_WAIT = 60;          // pipe is 47 deep
  localparam int LIMIT      = 400000;
  localparam int HOLD_LEN   = 300;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] sx;
    logic signed [WORD_W-1:0] sy;
    logic                     vis;
  } screen_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = OP_LOAD;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic signed [WORD_W-1:0] in_entry_value = '0;
  logic signed [WORD_W-1:0] in_point_x = '0;
  logic signed [WORD_W-1:0] in_point_y = '0;
  logic signed [WORD_W-1:0] in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_screen_x;
  logic signed [WORD_W-1:0] out_screen_y;
  logic out_visible;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFS_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [WORD_W-1:0] matrix_q [ENTRY_COUNT];
  logic [SIZE_W-1:0] view_w, view_h;
  logic signed [OFS_W-1:0] shift_x, shift_y;

  screen_t pending_screens[$];
  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  perspective_point_projector_top dut (.*);

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  // one clip-space row: translation plus three floor-shifted products
  function automatic longint row_sum(int base, logic signed [31:0] px,
                                     logic signed [31:0] py, logic signed [31:0] pz);
    longint acc;
    acc = longint'(matrix_q[base+3]);
    acc += (longint'(matrix_q[base])   * longint'(px)) >>> FB;
    acc += (longint'(matrix_q[base+1]) * longint'(py)) >>> FB;
    acc += (longint'(matrix_q[base+2]) * longint'(pz)) >>> FB;
    return acc;
  endfunction

  // sign(n) * min(trunc(|n| * size * 2^FB / d), 2^40)
  function automatic longint scaled_ratio(longint n, logic [SIZE_W-1:0] size, longint d);
    logic [127:0] mag, prod, q;
    mag  = (n < 0) ? 128'(-n) : 128'(n);
    prod = mag * (128'(size) << FB);
    q    = prod / 128'(d);
    if (q > 128'(Q_CAP)) q = 128'(Q_CAP);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic screen_t project_point(logic signed [31:0] px,
                                            logic signed [31:0] py, logic signed [31:0] pz);
    longint cx, cy, cw;
    screen_t r;
    cx = row_sum(0, px, py, pz);
    cy = row_sum(4, px, py, pz);
    cw = row_sum(8, px, py, pz);
    if (cw <= W_MIN) begin
      r = '0;
    end else begin
      r.sx  = clamp32(scaled_ratio(cx + cw, view_w, 2 * cw) + (longint'(shift_x) <<< FB));
      r.sy  = clamp32(scaled_ratio(cw - cy, view_h, 2 * cw) + (longint'(shift_y) <<< FB));
      r.vis = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    screen_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_screens.size() == 0) begin
        $error("result word with nothing expected");
        err_count++;
      end else begin
        exp_s = pending_screens.pop_front();
        if (out_screen_x !== exp_s.sx) begin
          $error("screen_x expected %0d got %0d", exp_s.sx, out_screen_x);
          err_count++;
        end
        if (out_screen_y !== exp_s.sy) begin
          $error("screen_y expected %0d got %0d", exp_s.sy, out_screen_y);
          err_count++;
        end
        if (out_visible !== exp_s.vis) begin
          $error("visible expected %0d got %0d", exp_s.vis, out_visible);
          err_count++;
        end
      end
    end
  end

  // receiver: random stall, or a long counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_word(logic op, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_point_x     <= px;
    in_point_y     <= py;
    in_point_z     <= pz;
    do @(posedge clk); while (in_stall);
    if (op == OP_PROJECT) pending_screens.push_back(project_point(px, py, pz));
    else if (idx < ENTRY_COUNT) matrix_q[idx] = val;
  endtask

  task automatic load_entry(int idx, logic [31:0] val);
    send_word(OP_LOAD, idx[3:0], val, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_word(OP_PROJECT, 4'($urandom), $urandom, px, py, pz);
  endtask

  // sender pauses until every expected word has come, then lets the pipe empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  view_w  = data[SIZE_W-1:0];
      REG_FRAME_HEIGHT: view_h  = data[SIZE_W-1:0];
      REG_OFFSET_X:     shift_x = data;
      REG_OFFSET_Y:     shift_y = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper bits of the size words are junk that must be masked off
  task automatic set_viewport(int w, int h, int ox, int oy);
    write_reg(REG_FRAME_WIDTH,  {2'($urandom), 14'(w)});
    write_reg(REG_FRAME_HEIGHT, {2'($urandom), 14'(h)});
    write_reg(REG_OFFSET_X, 16'(ox));
    write_reg(REG_OFFSET_Y, 16'(oy));
  endtask

  function automatic logic [31:0] rand_word();
    // mostly values within a few units, else full range
    if ($urandom_range(3) != 0) return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    return $urandom;
  endfunction

  // ---------------------------------------------------------------- tests
  // simple pinhole matrix: w = z
  task automatic test_pinhole_cases();
    for (int i = 0; i < ENTRY_COUNT; i++)
      load_entry(i, (i == 0 || i == 5 || i == 10) ? ONE : 32'h0);
    project(ONE, ONE, 32'h0002_0000);
    project(32'h0, 32'h0, 32'd65);            // w at the visibility limit
    project(32'h0, 32'h0, 32'd66);            // just in front
    project(ONE, ONE, 32'hffff_0000);         // behind the camera
    project(32'h7fff_ffff, 32'h8000_0000, 32'd100);   // saturates both coordinates high unless the frame size is zero
    project(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    project(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
    // ignored loads to entries past the matrix
    for (int i = ENTRY_COUNT; i < 16; i++) load_entry(i, 32'hdead_beef);
    project(ONE, 32'hffff_0000, 32'h0001_8000);
    drain();
  endtask

  task automatic test_extreme_matrix();
    load_entry(0, 32'h7fff_ffff);
    load_entry(3, 32'h8000_0000);
    load_entry(7, 32'h7fff_ffff);
    load_entry(11, 32'h7fff_ffff);
    project(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    project(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_random_stream(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) load_entry($urandom_range(15), rand_word());
      else project(rand_word(), rand_word(), rand_word());
    end
    drain();
  endtask

  // output held off long enough that the pipe fills and stalls its input
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 120; n++) project(rand_word(), rand_word(), rand_word());
    drain();
  endtask

  initial begin
    for (int i = 0; i < ENTRY_COUNT; i++) matrix_q[i] = '0;
    view_w = 1; view_h = 1; shift_x = 0; shift_y = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_pinhole_cases();                      // reset viewport
    set_viewport(640, 480, 0, 0);
    test_pinhole_cases();
    set_viewport(16383, 16383, 32767, -32768);
    test_extreme_matrix();
    set_viewport(0, 0, -32768, 32767);         // zero size leaves the offset
    test_pinhole_cases();

    send_idle_pct = 37; recv_idle_pct = 53;
    set_viewport($urandom_range(1, 2000), $urandom_range(1, 2000),
                 $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
    test_random_stream(500);
    send_idle_pct = 53; recv_idle_pct = 37;
    set_viewport($urandom_range(16383), $urandom_range(16383), $urandom, $urandom);
    test_random_stream(500);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_viewport(1920, 1080, 16, -16);
    test_random_stream(500);
    test_backpressure();

    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
